/* sv/kf3_pkg.sv */
// kf3_pkg: shared types, constants and helpers for the three-state Kalman filter.
// No dependencies; imported by the top level, kalman_filter_3state_scalar.

package kf3_pkg;

    // Default fraction width of the Q format
    localparam int KF3_FRAC_BITS = 16;

    // Number of products in the update pass: 3 state rows + 9 covariance entries
    localparam int KF3_NPROD = 12;

    // Configuration register indexes
    localparam logic KF3_REG_MEAS_NOISE = 1'b0;
    localparam logic KF3_REG_PROC_NOISE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIVGO,
        ST_DIVWT,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    // Covariance row for update product k (k >= 3); rows 1, 2, then row 0 last
    // so that row 0 of the prediction stays intact while the others read it.
    function automatic logic [1:0] kf3_row(input logic [3:0] k);
        logic [1:0] row;
        case (k)
            4'd3, 4'd4, 4'd5:    row = 2'd1;
            4'd6, 4'd7, 4'd8:    row = 2'd2;
            default:             row = 2'd0;
        endcase
        return row;
    endfunction

    // Covariance column for update product k
    function automatic logic [1:0] kf3_col(input logic [3:0] k);
        logic [1:0] col;
        case (k)
            4'd3, 4'd6, 4'd9:    col = 2'd0;
            4'd4, 4'd7, 4'd10:   col = 2'd1;
            default:             col = 2'd2;
        endcase
        return col;
    endfunction

endpackage

/* sv/kf3_mul.sv */
// kf3_mul: shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on nothing; used by the top-level sequencer for every update product.

module kf3_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    // One multiply per cycle; the product is registered and appears in the next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* sv/kf3_div.sv */
// kf3_div: restoring bit-serial signed divider, quotient truncated toward zero.
// Depends on nothing; the top level computes the Kalman gain with it.

module kf3_div #(
    parameter int NW = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [32:0] i_den,
    output logic              o_done,
    output logic [31:0]       o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [32:0]   r_rem;
    logic [32:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [33:0]   trial;
    logic          fits;
    logic [NW-1:0] num_mag;
    logic [32:0]   den_mag;
    logic [31:0]   quo_lo;

    // Operand magnitudes
    assign num_mag = i_num[NW-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[32]   ? (~i_den + 1'b1) : i_den;

    // One quotient bit per cycle
    assign trial = {r_rem, r_num[NW-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= num_mag;
            r_den <= den_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_num[NW-1] ^ i_den[32];
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= fits ? 33'(trial - {1'b0, r_den}) : trial[32:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    // Sign and wrap to 32 bits
    assign quo_lo = r_quo[31:0];
    assign o_quot = r_neg ? (~quo_lo + 1'b1) : quo_lo;
    assign o_done = r_done;

endmodule

/* sv/kalman_filter_3state_scalar.sv */
// kalman_filter_3state_scalar: three-state constant-acceleration Kalman filter.
// Depends on kf3_pkg, kf3_mul and kf3_div.
//
//  channel    | direction | handshake                      | payload
//  -----------+-----------+--------------------------------+----------------------
//  meas       | in        | i_meas_valid / o_meas_ready    | i_meas  (s32 Q16.16)
//  est        | out       | o_est_valid  / i_est_ready     | o_est_pos (s32)
//  config     | in        | i_cfg_we (no wait)             | i_cfg_idx, i_cfg_data
//
// A beat runs one prediction step, up to three gain divides of FRAC_BITS+32 steps
// each in the serial divider (skipped, with zero gains, when the innovation variance
// is zero), and twelve multiply/accumulate passes through the one shared multiplier.
// o_meas_ready is high only while idle; a finished estimate sits in the output
// register, so the next beat may be taken while it waits. Synchronous reset clears
// the state estimate, covariance and output valid; noise registers load 1000.0/1.0.

module kalman_filter_3state_scalar
    import kf3_pkg::*;
#(
    parameter int FRAC_BITS = KF3_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_meas_valid,
    output logic               o_meas_ready,
    input  logic signed [31:0] i_meas,
    output logic               o_est_valid,
    input  logic               i_est_ready,
    output logic signed [31:0] o_est_pos,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);

    localparam int NW = 32 + FRAC_BITS;
    localparam logic [30:0] RST_MEAS = 31'(64'd1000 << FRAC_BITS);
    localparam logic [30:0] RST_PROC = 31'(64'd1 << FRAC_BITS);

    t_state r_state, n_state;

    logic [31:0] r_x [3];
    logic [31:0] r_p [9];
    logic [31:0] r_gain [3];
    logic [31:0] r_z;
    logic [31:0] r_resid;
    logic [30:0] r_meas_noise;
    logic [30:0] r_proc_noise;
    logic [1:0]  r_row;
    logic [3:0]  r_k;
    logic        r_est_valid;
    logic [31:0] r_est_pos;

    // Prediction
    logic [31:0] ap [9];
    logic [31:0] pp [9];
    logic [31:0] xp [3];

    // Gain divide
    logic signed [32:0]   s_val;
    logic                 s_zero;
    logic signed [NW-1:0] div_num;
    logic                 div_start;
    logic                 div_done;
    logic [31:0]          div_quot;

    // Update multiply/accumulate
    logic [1:0]         k_row;
    logic [1:0]         k_col;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic [31:0]        acc_base;
    logic signed [63:0] base_ext;
    logic signed [63:0] acc_sum;
    logic [31:0]        acc_res;
    logic               last_k;

    // A*P, then (A*P)*A' + qI, and A*x, all wrapping 32-bit sums
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ap[c]     = r_p[c] + r_p[3 + c];
            ap[3 + c] = r_p[3 + c] + r_p[6 + c];
            ap[6 + c] = r_p[6 + c];
        end
        for (int r = 0; r < 3; r++) begin
            pp[3*r]     = ap[3*r] + ap[3*r + 1];
            pp[3*r + 1] = ap[3*r + 1] + ap[3*r + 2];
            pp[3*r + 2] = ap[3*r + 2];
        end
        pp[0] = pp[0] + {1'b0, r_proc_noise};
        pp[4] = pp[4] + {1'b0, r_proc_noise};
        pp[8] = pp[8] + {1'b0, r_proc_noise};
        xp[0] = r_x[0] + r_x[1];
        xp[1] = r_x[1] + r_x[2];
        xp[2] = r_x[2];
    end

    // Innovation variance, formed without wrap
    assign s_val  = 33'(signed'(r_p[0])) + signed'({2'b00, r_meas_noise});
    assign s_zero = (s_val == '0);

    always_comb begin
        case (r_row)
            2'd1:    div_num = NW'(signed'(r_p[3])) <<< FRAC_BITS;
            2'd2:    div_num = NW'(signed'(r_p[6])) <<< FRAC_BITS;
            default: div_num = NW'(signed'(r_p[0])) <<< FRAC_BITS;
        endcase
    end

    kf3_div #(
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (s_val),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Operand selection for product k
    assign k_row  = kf3_row(r_k);
    assign k_col  = kf3_col(r_k);
    assign last_k = (r_k == 4'(KF3_NPROD - 1));

    always_comb begin
        if (r_k < 4'd3) begin
            mul_a    = signed'(r_gain[r_k[1:0]]);
            mul_b    = signed'(r_resid);
            acc_base = r_x[r_k[1:0]];
        end else begin
            mul_a    = signed'(r_gain[k_row]);
            mul_b    = signed'(r_p[k_col]);
            acc_base = r_p[4'(k_row) * 4'd3 + 4'(k_col)];
        end
    end

    kf3_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // base*2^F +/- product, floor shift by F, wrap to 32 bits
    assign base_ext = 64'(signed'(acc_base)) <<< FRAC_BITS;
    assign acc_sum  = (r_k < 4'd3) ? (base_ext + prod) : (base_ext - prod);
    assign acc_res  = 32'(acc_sum >>> FRAC_BITS);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_meas_valid) n_state = ST_PRED;
            ST_PRED:  n_state = ST_DIVGO;
            ST_DIVGO: begin
                if (!s_zero)             n_state = ST_DIVWT;
                else if (r_row == 2'd2)  n_state = ST_MUL;
            end
            ST_DIVWT: begin
                if (div_done) n_state = (r_row == 2'd2) ? ST_MUL : ST_DIVGO;
            end
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = last_k ? ST_DONE : ST_MUL;
            ST_DONE:  if (!r_est_valid || i_est_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_meas_ready = 1'b0;
        div_start    = 1'b0;
        case (r_state)
            ST_IDLE:  o_meas_ready = 1'b1;
            ST_DIVGO: div_start    = !s_zero;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_noise <= RST_MEAS;
            r_proc_noise <= RST_PROC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                KF3_REG_MEAS_NOISE: r_meas_noise <= i_cfg_data;
                KF3_REG_PROC_NOISE: r_proc_noise <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // Filter state and sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_x[i] <= '0;
            for (int i = 0; i < 9; i++) r_p[i] <= '0;
            r_row <= '0;
            r_k   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_meas_valid) r_z <= i_meas;
                end
                ST_PRED: begin
                    for (int i = 0; i < 3; i++) r_x[i] <= xp[i];
                    for (int i = 0; i < 9; i++) r_p[i] <= pp[i];
                    r_resid <= r_z - xp[0];
                    r_row   <= 2'd0;
                    r_k     <= '0;
                end
                ST_DIVGO: begin
                    if (s_zero) begin
                        r_gain[r_row] <= '0;
                        r_row         <= r_row + 1'b1;
                    end
                end
                ST_DIVWT: begin
                    if (div_done) begin
                        r_gain[r_row] <= div_quot;
                        r_row         <= r_row + 1'b1;
                    end
                end
                ST_ACC: begin
                    if (r_k < 4'd3) r_x[r_k[1:0]] <= acc_res;
                    else            r_p[4'(k_row) * 4'd3 + 4'(k_col)] <= acc_res;
                    r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est_valid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_est_valid || i_est_ready)) begin
            r_est_valid <= 1'b1;
            r_est_pos   <= r_x[0];
        end else if (i_est_ready) begin
            r_est_valid <= 1'b0;
        end
    end

    assign o_est_valid = r_est_valid;
    assign o_est_pos   = r_est_pos;

endmodule

/* sv/kf3_checker.sv */
// kf3_checker: port-level assertions for kalman_filter_3state_scalar.
// Depends on nothing; bound to the top level at the end of this file.

module kf3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_meas_valid,
    input logic        o_meas_ready,
    input logic        o_est_valid,
    input logic        i_est_ready,
    input logic [31:0] o_est_pos
);

    // Output valid is cleared by reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_est_valid)
        else $error("est valid set after reset");

    // Block goes busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_meas_valid && o_meas_ready |=> !o_meas_ready)
        else $error("ready held after accept");

    // An estimate never appears the cycle after a beat is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_est_valid) |-> !$past(i_meas_valid && o_meas_ready))
        else $error("estimate too early");

    // Stalled estimate holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_est_valid && !i_est_ready |=> o_est_valid && $stable(o_est_pos))
        else $error("stalled estimate changed");

endmodule

bind kalman_filter_3state_scalar kf3_checker u_kf3_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_meas_valid (i_meas_valid),
    .o_meas_ready (o_meas_ready),
    .o_est_valid  (o_est_valid),
    .i_est_ready  (i_est_ready),
    .o_est_pos    (o_est_pos)
);
